FILE: src/stl_pkg.sv
// Shared types and constants for the source token lexer.
`timescale 1ns / 1ps

package stl_pkg;

  localparam int DEF_POSITION_BITS = 32;
  localparam int DEF_LENGTH_BITS   = 16;

  localparam int KIND_BITS         = 5;
  localparam int TOKEN_START_BITS  = 32;
  localparam int TOKEN_LENGTH_BITS = 16;

  localparam int QUEUE_DEPTH = 4;

  // Keywords are matched on the first six bytes of an identifier, packed MSB first.
  localparam int KEYWORD_BYTES = 6;
  localparam int KEYWORD_BITS  = 8 * KEYWORD_BYTES;
  localparam int KEYWORD_COUNT = 6;

  localparam logic [KEYWORD_BITS-1:0] KW_TEXT [KEYWORD_COUNT] = '{
    48'h0000_7769_7468,  // with
    48'h0000_0069_6e74,  // int
    48'h0000_0000_6966,  // if
    48'h0000_656c_7365,  // else
    48'h0077_6869_6c65,  // while
    48'h7265_7475_726e   // return
  };
  localparam logic [2:0] KW_LEN [KEYWORD_COUNT] = '{3'd4, 3'd3, 3'd2, 3'd4, 3'd5, 3'd6};

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_EOF,
    KIND_UNKNOWN,
    KIND_IDENT,
    KIND_NUMBER,
    KIND_WITH,
    KIND_INT,
    KIND_IF,
    KIND_ELSE,
    KIND_WHILE,
    KIND_RETURN,
    KIND_EQ_EQ,
    KIND_NOT_EQ,
    KIND_LESS_EQ,
    KIND_GREATER_EQ,
    KIND_PLUS,
    KIND_MINUS,
    KIND_STAR,
    KIND_SLASH,
    KIND_LESS,
    KIND_GREATER,
    KIND_COMMA,
    KIND_COLON,
    KIND_ASSIGN,
    KIND_SEMI,
    KIND_LPAREN,
    KIND_RPAREN,
    KIND_LBRACE,
    KIND_RBRACE
  } kind_t;

  typedef struct packed {
    kind_t                        kind;
    logic [TOKEN_START_BITS-1:0]  start;
    logic [TOKEN_LENGTH_BITS-1:0] length;
  } token_t;

  // Everything one input beat produces: an optional flushed token, then an
  // optional token of its own.
  typedef struct packed {
    logic   first_valid;
    token_t first;
    logic   second_valid;
    token_t second;
  } rec_t;

endpackage

FILE: src/stl_byte_if.sv
// Input channel carrying source bytes.
`timescale 1ns / 1ps

interface stl_byte_if ();
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_input;

  modport source(output valid, text_byte, end_of_input, input ready);
  modport sink(input valid, text_byte, end_of_input, output ready);
endinterface

FILE: src/stl_rec_if.sv
// Internal channel carrying per-byte token records between front and back.
`timescale 1ns / 1ps

interface stl_rec_if import stl_pkg::*; ();
  logic valid;
  logic ready;
  rec_t rec;

  modport source(output valid, rec, input ready);
  modport sink(input valid, rec, output ready);
endinterface

FILE: src/stl_token_if.sv
// Output channel carrying tokens.
`timescale 1ns / 1ps

interface stl_token_if import stl_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [KIND_BITS-1:0]         token_kind;
  logic [TOKEN_START_BITS-1:0]  token_start;
  logic [TOKEN_LENGTH_BITS-1:0] token_length;
  logic                         last_of_item;

  modport source(output valid, token_kind, token_start, token_length, last_of_item,
                 input ready);
  modport sink(input valid, token_kind, token_start, token_length, last_of_item,
               output ready);
endinterface

FILE: src/stl_front.sv
// Front end: classify each byte, run the scan state machine, build token records.
`timescale 1ns / 1ps

module stl_front import stl_pkg::*; #(
  parameter int POSITION_BITS = DEF_POSITION_BITS,
  parameter int LENGTH_BITS   = DEF_LENGTH_BITS
) (
  input  logic       clk,
  input  logic       rst,
  stl_byte_if.sink   text,
  stl_rec_if.source  rec
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_EQ,
    MODE_BANG,
    MODE_LT,
    MODE_GT
  } mode_t;

  mode_t                    mode, mode_next;
  logic [POSITION_BITS-1:0] position, position_next;
  logic [POSITION_BITS-1:0] token_begin, token_begin_next;
  logic [KEYWORD_BITS-1:0]  prefix, prefix_next;
  logic [LENGTH_BITS-1:0]   run_length, run_length_next;

  logic [7:0]              c;
  logic                    is_end, is_space, is_digit, is_alpha, is_id_start, is_id_char;
  logic                    accept, pair_mode;
  logic [KEYWORD_BITS-1:0] ext_prefix;
  logic [LENGTH_BITS-1:0]  ext_run;
  kind_t                   flush_kind, pair_kind;
  token_t                  flush_tok;
  rec_t                    out_rec;

  function automatic kind_t ident_kind(logic [KEYWORD_BITS-1:0] p, logic [LENGTH_BITS-1:0] n);
    kind_t k;
    k = KIND_IDENT;
    for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
      if (n == LENGTH_BITS'(KW_LEN[i]) && p == KW_TEXT[i]) begin
        k = kind_t'(KIND_BITS'(int'(KIND_WITH) + i));
      end
    end
    return k;
  endfunction

  function automatic kind_t single_kind(logic [7:0] b);
    kind_t k;
    unique case (b)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      ",":     k = KIND_COMMA;
      ":":     k = KIND_COLON;
      ";":     k = KIND_SEMI;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  assign c           = text.text_byte;
  assign is_end      = text.end_of_input || (c == 8'h00);
  assign is_space    = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  assign is_digit    = (c >= "0") && (c <= "9");
  assign is_alpha    = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  assign is_id_start = is_alpha || (c == CH_UNDERSCORE);
  assign is_id_char  = is_id_start || is_digit;

  assign text.ready = rec.ready;
  assign accept     = text.valid && rec.ready;
  assign pair_mode  = (mode == MODE_EQ) || (mode == MODE_BANG) ||
                      (mode == MODE_LT) || (mode == MODE_GT);

  // Grow the pending token: keep the first six bytes, saturate the count.
  assign ext_prefix = (run_length < LENGTH_BITS'(KEYWORD_BYTES)) ?
                      {prefix[KEYWORD_BITS-9:0], c} : prefix;
  assign ext_run    = (run_length != '1) ? run_length + LENGTH_BITS'(1) : run_length;

  always_comb begin
    unique case (mode)
      MODE_IDENT:  flush_kind = ident_kind(prefix, run_length);
      MODE_NUMBER: flush_kind = KIND_NUMBER;
      MODE_EQ:     flush_kind = KIND_ASSIGN;
      MODE_BANG:   flush_kind = KIND_UNKNOWN;
      MODE_LT:     flush_kind = KIND_LESS;
      MODE_GT:     flush_kind = KIND_GREATER;
      default:     flush_kind = KIND_UNKNOWN;
    endcase
    unique case (mode)
      MODE_EQ:   pair_kind = KIND_EQ_EQ;
      MODE_BANG: pair_kind = KIND_NOT_EQ;
      MODE_LT:   pair_kind = KIND_LESS_EQ;
      default:   pair_kind = KIND_GREATER_EQ;
    endcase
  end

  assign flush_tok.kind   = flush_kind;
  assign flush_tok.start  = TOKEN_START_BITS'(token_begin);
  assign flush_tok.length = TOKEN_LENGTH_BITS'(run_length);

  always_comb begin
    mode_next        = mode;
    position_next    = position;
    token_begin_next = token_begin;
    prefix_next      = prefix;
    run_length_next  = run_length;
    out_rec          = '0;

    if (is_end) begin
      // Flush, then EoF at the current offset; the scanner restarts from zero.
      out_rec.first_valid   = (mode != MODE_IDLE);
      out_rec.first         = flush_tok;
      out_rec.second_valid  = 1'b1;
      out_rec.second.kind   = KIND_EOF;
      out_rec.second.start  = TOKEN_START_BITS'(position);
      out_rec.second.length = '0;
      mode_next        = MODE_IDLE;
      position_next    = '0;
      token_begin_next = '0;
      prefix_next      = '0;
      run_length_next  = '0;
    end else begin
      position_next = position + POSITION_BITS'(1);
      if ((mode == MODE_IDENT && is_id_char) || (mode == MODE_NUMBER && is_digit)) begin
        prefix_next     = ext_prefix;
        run_length_next = ext_run;
      end else if (c == "=" && pair_mode) begin
        out_rec.first_valid  = 1'b1;
        out_rec.first.kind   = pair_kind;
        out_rec.first.start  = TOKEN_START_BITS'(token_begin);
        out_rec.first.length = TOKEN_LENGTH_BITS'(2);
        mode_next            = MODE_IDLE;
      end else begin
        out_rec.first_valid = (mode != MODE_IDLE);
        out_rec.first       = flush_tok;
        mode_next           = MODE_IDLE;
        if (!is_space) begin
          token_begin_next = position;
          prefix_next      = '0;
          run_length_next  = LENGTH_BITS'(1);
          if (is_id_start) begin
            mode_next   = MODE_IDENT;
            prefix_next = KEYWORD_BITS'(c);
          end else if (is_digit) begin
            mode_next   = MODE_NUMBER;
            prefix_next = KEYWORD_BITS'(c);
          end else begin
            priority case (c)
              "=": mode_next = MODE_EQ;
              "!": mode_next = MODE_BANG;
              "<": mode_next = MODE_LT;
              ">": mode_next = MODE_GT;
              default: begin
                run_length_next       = '0;
                out_rec.second_valid  = 1'b1;
                out_rec.second.kind   = single_kind(c);
                out_rec.second.start  = TOKEN_START_BITS'(position);
                out_rec.second.length = TOKEN_LENGTH_BITS'(1);
              end
            endcase
          end
        end
      end
    end
  end

  assign rec.valid = text.valid && (out_rec.first_valid || out_rec.second_valid);
  assign rec.rec   = out_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      position    <= '0;
      token_begin <= '0;
      prefix      <= '0;
      run_length  <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      position    <= position_next;
      token_begin <= token_begin_next;
      prefix      <= prefix_next;
      run_length  <= run_length_next;
    end
  end

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && is_end) |=> (position == '0 && mode == MODE_IDLE))
    else $error("offset not restarted after end of input");

  a_offset_advances: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_end) |=> (position == $past(position + POSITION_BITS'(1))))
    else $error("offset did not advance by one on a text byte");

endmodule

FILE: src/stl_queue.sv
// Short record queue decoupling the scanner from the token output.
`timescale 1ns / 1ps

module stl_queue import stl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  stl_rec_if.sink   wr,
  stl_rec_if.source rd
);

  localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  rec_t                  slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [COUNT_BITS-1:0] count;
  logic                  push, pop;

  assign wr.ready = (count != COUNT_BITS'(QUEUE_DEPTH));
  assign rd.valid = (count != '0);
  assign rd.rec   = slots[rd_ptr];
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + COUNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_BITS'(1);
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + COUNT_BITS'(1)))
    else $error("queue occupancy lost a push");

endmodule

FILE: src/stl_back.sv
// Back end: drain each record as one or two token beats and mark the last one.
`timescale 1ns / 1ps

module stl_back import stl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  stl_rec_if.sink     rec,
  stl_token_if.source tokens
);

  logic   phase;
  logic   on_second, last, take;
  token_t shown;

  // Show the second token once the first has gone, or when there was no first.
  assign on_second = phase || !rec.rec.first_valid;
  assign shown     = on_second ? rec.rec.second : rec.rec.first;
  assign last      = on_second || !rec.rec.second_valid;
  assign take      = rec.valid && tokens.ready;

  assign tokens.valid        = rec.valid;
  assign tokens.token_kind   = shown.kind;
  assign tokens.token_start  = shown.start;
  assign tokens.token_length = shown.length;
  assign tokens.last_of_item = last;
  assign rec.ready           = tokens.ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (take) begin
      phase <= !last;
    end
  end

  a_phase_needs_pair: assert property (@(posedge clk) disable iff (rst)
    phase |-> (rec.valid && rec.rec.first_valid && rec.rec.second_valid))
    else $error("second half of a record shown without a pair");

endmodule

FILE: src/source_token_lexer.sv
// Top level of the streaming source token lexer.
`timescale 1ns / 1ps
// Throughput: one text byte per cycle while the record queue has room; a byte
//   that yields two tokens sends a beat for each; the queue absorbs the burst.
// A byte's tokens are registered in the record queue and shown from its head.
// Reset (synchronous, rst high): clears scan mode, offset, pending token, the
//   record queue and the output phase; ready the next cycle, no clearing pass.

module source_token_lexer import stl_pkg::*; #(
  parameter int POSITION_BITS = DEF_POSITION_BITS,
  parameter int LENGTH_BITS   = DEF_LENGTH_BITS
) (
  input  logic        clk,
  input  logic        rst,
  stl_byte_if.sink    text,
  stl_token_if.source tokens
);

  // Scanner output into the queue, and queue head into the output stage.
  stl_rec_if scan_ch ();
  stl_rec_if drain_ch ();

  // Front end: one byte a beat, classify it and advance the scan state.
  stl_front #(
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_front (
    .clk (clk),
    .rst (rst),
    .text(text),
    .rec (scan_ch.source)
  );

  // Hold records while the token consumer stalls.
  stl_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr (scan_ch.sink),
    .rd (drain_ch.source)
  );

  // Back end: split each record into its token beats.
  stl_back u_back (
    .clk   (clk),
    .rst   (rst),
    .rec   (drain_ch.sink),
    .tokens(tokens)
  );

endmodule

FILE: dv/lexer_token_checker.sv
// Checker for the source token lexer: predicts tokens from input beats and compares.
`timescale 1ns / 1ps

module lexer_token_checker import stl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  stl_byte_if   text,
  stl_token_if  tokens,
  output int    mismatch_count,
  output int    tokens_outstanding
);

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_NUMBER,
    SCAN_EQ,
    SCAN_BANG,
    SCAN_LT,
    SCAN_GT
  } scan_t;

  typedef struct packed {
    kind_t                        kind;
    logic [TOKEN_START_BITS-1:0]  start;
    logic [TOKEN_LENGTH_BITS-1:0] length;
    logic                         last;
  } token_exp_t;

  localparam logic [TOKEN_LENGTH_BITS-1:0] RUN_MAX = '1;
  localparam logic [TOKEN_LENGTH_BITS-1:0] LEN_ONE = TOKEN_LENGTH_BITS'(1);
  localparam logic [TOKEN_LENGTH_BITS-1:0] LEN_TWO = TOKEN_LENGTH_BITS'(2);
  localparam int PREFIX_BYTES = 6;

  localparam logic [47:0] KEYWORD_WORDS [6] = '{"with", "int", "if", "else", "while", "return"};
  localparam int          KEYWORD_SIZES [6] = '{4, 3, 2, 4, 5, 6};

  token_exp_t expected_tokens [$];
  token_exp_t beat_tokens [2];
  int         beat_count;

  scan_t                        scan;
  logic [31:0]                  offset;
  logic [31:0]                  begin_off;
  logic [47:0]                  prefix;
  logic [TOKEN_LENGTH_BITS-1:0] run;

  function automatic bit is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_ident_head(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic kind_t ident_kind();
    for (int k = 0; k < 6; k++) begin
      if (run == KEYWORD_SIZES[k] && prefix == KEYWORD_WORDS[k])
        return kind_t'(int'(KIND_WITH) + k);
    end
    return KIND_IDENT;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic add_token(input kind_t kind, input logic [31:0] start,
                           input logic [TOKEN_LENGTH_BITS-1:0] len);
    beat_tokens[beat_count] = '{kind, start, len, 1'b0};
    beat_count++;
  endtask

  task automatic grow_run(input logic [7:0] c);
    if (run < PREFIX_BYTES) prefix = {prefix[39:0], c};
    if (run != RUN_MAX) run++;
  endtask

  task automatic flush_pending();
    case (scan)
      SCAN_IDENT:  add_token(ident_kind(), begin_off, run);
      SCAN_NUMBER: add_token(KIND_NUMBER, begin_off, run);
      SCAN_EQ:     add_token(KIND_ASSIGN, begin_off, run);
      SCAN_BANG:   add_token(KIND_UNKNOWN, begin_off, run);
      SCAN_LT:     add_token(KIND_LESS, begin_off, run);
      SCAN_GT:     add_token(KIND_GREATER, begin_off, run);
      default: ;
    endcase
    scan = SCAN_IDLE;
  endtask

  task automatic start_token(input logic [7:0] c);
    if (!is_space(c)) begin
      begin_off = offset;
      prefix    = '0;
      run       = '0;
      if (is_ident_head(c)) begin
        scan = SCAN_IDENT;
        grow_run(c);
      end else if (is_digit(c)) begin
        scan = SCAN_NUMBER;
        grow_run(c);
      end else begin
        case (c)
          "=": begin scan = SCAN_EQ;   run = LEN_ONE; end
          "!": begin scan = SCAN_BANG; run = LEN_ONE; end
          "<": begin scan = SCAN_LT;   run = LEN_ONE; end
          ">": begin scan = SCAN_GT;   run = LEN_ONE; end
          "+": add_token(KIND_PLUS, offset, LEN_ONE);
          "-": add_token(KIND_MINUS, offset, LEN_ONE);
          "*": add_token(KIND_STAR, offset, LEN_ONE);
          "/": add_token(KIND_SLASH, offset, LEN_ONE);
          ",": add_token(KIND_COMMA, offset, LEN_ONE);
          ":": add_token(KIND_COLON, offset, LEN_ONE);
          ";": add_token(KIND_SEMI, offset, LEN_ONE);
          "(": add_token(KIND_LPAREN, offset, LEN_ONE);
          ")": add_token(KIND_RPAREN, offset, LEN_ONE);
          "{": add_token(KIND_LBRACE, offset, LEN_ONE);
          "}": add_token(KIND_RBRACE, offset, LEN_ONE);
          default: add_token(KIND_UNKNOWN, offset, LEN_ONE);
        endcase
      end
    end
  endtask

  task automatic clear_scan();
    scan      = SCAN_IDLE;
    offset    = '0;
    begin_off = '0;
    prefix    = '0;
    run       = '0;
  endtask

  task automatic predict_tokens(input logic [7:0] c, input logic eoi);
    kind_t pair;
    beat_count = 0;
    if (eoi || c == 8'h00) begin
      flush_pending();
      add_token(KIND_EOF, offset, '0);
      clear_scan();
    end else begin
      if (scan == SCAN_IDENT && (is_ident_head(c) || is_digit(c))) begin
        grow_run(c);
      end else if (scan == SCAN_NUMBER && is_digit(c)) begin
        grow_run(c);
      end else if (c == "=" && scan inside {SCAN_EQ, SCAN_BANG, SCAN_LT, SCAN_GT}) begin
        case (scan)
          SCAN_EQ:   pair = KIND_EQ_EQ;
          SCAN_BANG: pair = KIND_NOT_EQ;
          SCAN_LT:   pair = KIND_LESS_EQ;
          default:   pair = KIND_GREATER_EQ;
        endcase
        add_token(pair, begin_off, LEN_TWO);
        scan = SCAN_IDLE;
      end else begin
        flush_pending();
        start_token(c);
      end
      offset = offset + 32'd1;
    end
    if (beat_count > 0) beat_tokens[beat_count-1].last = 1'b1;
    for (int i = 0; i < beat_count; i++) expected_tokens.push_back(beat_tokens[i]);
  endtask

  task automatic check_token();
    token_exp_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("unexpected token beat kind %0d start %0d length %0d",
                                tokens.token_kind, tokens.token_start, tokens.token_length));
    end else begin
      want = expected_tokens.pop_front();
      if (tokens.token_kind !== want.kind)
        report_mismatch($sformatf("token_kind got %0d want %0d (start %0d)",
                                  tokens.token_kind, want.kind, want.start));
      if (tokens.token_start !== want.start)
        report_mismatch($sformatf("token_start got %0d want %0d",
                                  tokens.token_start, want.start));
      if (tokens.token_length !== want.length)
        report_mismatch($sformatf("token_length got %0d want %0d (start %0d)",
                                  tokens.token_length, want.length, want.start));
      if (tokens.last_of_item !== want.last)
        report_mismatch($sformatf("last_of_item got %b want %b (start %0d)",
                                  tokens.last_of_item, want.last, want.start));
    end
  endtask

  // Compare first: a token leaving now can only stem from an earlier byte.
  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      expected_tokens.delete();
    end else begin
      if (tokens.valid && tokens.ready) check_token();
      if (text.valid && text.ready) predict_tokens(text.text_byte, text.end_of_input);
    end
    tokens_outstanding = expected_tokens.size();
  end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the source token lexer: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before giving up
  localparam int DRAIN_CYCLES   = 20;    // settle time once nothing is expected
  localparam int HOLD_CYCLES    = 400;   // long receiver stall to back the block up
  localparam int BYTES_PER_PHASE = 234;

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
  } text_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  stl_byte_if  text_ch ();
  stl_token_if tok_ch ();

  int mismatch_count;
  int tokens_outstanding;

  int send_idle_pct;
  int recv_idle_pct;

  logic byte_taken  = 1'b0;
  logic hold_request = 1'b0;
  bit   hold_done;
  int   hold_left;
  int   quiet_cycles;

  text_beat_t beat_queue [$];

  string keyword_words [6] = '{"with", "int", "if", "else", "while", "return"};
  string op_words [18] = '{"==", "!=", "<=", ">=", "+", "-", "*", "/", "<", ">",
                           ",", ":", "=", ";", "(", ")", "{", "}"};
  string ident_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string ident_body = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

  // 4 ns period: two half-period delays.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  source_token_lexer u_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .tokens (tok_ch)
  );

  lexer_token_checker u_chk (
    .clk                (clk),
    .rst                (rst),
    .text               (text_ch),
    .tokens             (tok_ch),
    .mismatch_count     (mismatch_count),
    .tokens_outstanding (tokens_outstanding)
  );

  // Capture the input handshake at the rising edge; the driver reads it at the
  // following falling edge, so there is no race with the block's own update.
  always @(posedge clk) begin
    byte_taken <= text_ch.valid && text_ch.ready;
  end

  // Watchdog: end the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((text_ch.valid && text_ch.ready) || (tok_ch.valid && tok_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off for a long stretch once asked.
  initial begin
    tok_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        tok_ch.ready = 1'b0;
        hold_left--;
      end else begin
        tok_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic queue_byte(input logic [7:0] ch, input logic eoi = 1'b0);
    beat_queue.push_back('{ch, eoi});
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  // One token-shaped chunk of text; mostly well formed, some noise and ends.
  task automatic queue_random_token();
    int pick;
    int len;
    logic [7:0] ws;
    pick = $urandom_range(99);
    if (pick < 12) begin
      queue_text(keyword_words[$urandom_range(5)]);
    end else if (pick < 30) begin
      // Some identifiers start as a keyword and run on past it.
      if ($urandom_range(3) == 0) queue_text(keyword_words[$urandom_range(5)]);
      else queue_byte(ident_head[$urandom_range(ident_head.len() - 1)]);
      len = $urandom_range(9);
      repeat (len) queue_byte(ident_body[$urandom_range(ident_body.len() - 1)]);
    end else if (pick < 45) begin
      len = $urandom_range(1, 8);
      repeat (len) queue_byte(8'($urandom_range("0", "9")));
    end else if (pick < 70) begin
      queue_text(op_words[$urandom_range(17)]);
    end else if (pick < 88) begin
      len = $urandom_range(1, 3);
      repeat (len) begin
        ws = 8'($urandom_range(9, 14));
        if (ws == 8'd14) ws = 8'd32;
        queue_byte(ws);
      end
    end else if (pick < 93) begin
      queue_byte(8'($urandom_range(255)));
    end else if (pick < 96) begin
      queue_text("!");
    end else begin
      // End of buffer: either the end flag with a junk byte, or a zero byte.
      if ($urandom_range(1) == 1) queue_byte(8'($urandom_range(255)), 1'b1);
      else queue_byte(8'h00);
    end
  endtask

  // Offer one beat, idling cycle by cycle at random, and hold it until it is taken.
  task automatic send_beat(input text_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      text_ch.valid = 1'b0;
      @(negedge clk);
    end
    text_ch.valid        = 1'b1;
    text_ch.text_byte    = b.ch;
    text_ch.end_of_input = b.eoi;
    do @(negedge clk); while (!byte_taken);
  endtask

  task automatic send_queued();
    while (beat_queue.size() > 0) send_beat(beat_queue.pop_front());
  endtask

  initial begin
    text_ch.valid        = 1'b0;
    text_ch.text_byte    = 8'h00;
    text_ch.end_of_input = 1'b0;
    send_idle_pct        = 0;
    recv_idle_pct        = 0;

    repeat (10) @(negedge clk);
    rst = 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 34; recv_idle_pct = 85; end
        1: begin send_idle_pct = 85; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase

      if (phase == 0) begin
        // Keyword run-on, != pair, number, then '<' flushed by an end item.
        queue_text("returnx!=9<");
        queue_byte(8'hFF, 1'b1);
        // Identifier ended by a one-byte token: two tokens from one beat.
        queue_text("a;");
        // Lone bang then a letter, high bytes that each give an unknown token.
        queue_text("!b");
        queue_byte(8'hFF);
        queue_byte(8'h80);
        queue_text("==>=<=>");
        // Zero byte flushes the pending '>' and ends the buffer.
        queue_byte(8'h00);
      end

      if (phase == 2) begin
        // Stall the receiver hard while bytes keep coming.
        hold_request = 1'b1;
      end

      while (beat_queue.size() < BYTES_PER_PHASE) queue_random_token();

      send_queued();
    end

    text_ch.valid = 1'b0;

    // Drain: wait for every predicted token, then let the pipe settle.
    while (tokens_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
src/stl_pkg.sv
src/stl_byte_if.sv
src/stl_rec_if.sv
src/stl_token_if.sv
src/stl_front.sv
src/stl_queue.sv
src/stl_back.sv
src/source_token_lexer.sv
dv/lexer_token_checker.sv
dv/tb_top.sv
